@@ src/bir_pkg.sv @@
// ----------------------------------------------------------------------------
// Bilinear image resize package
// Shared constants, register indexes and opcodes.
// ----------------------------------------------------------------------------
package bir_pkg;
    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int MAX_CHANNELS   = 3;
    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_DST_DIM    = 4096;

    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_NUM_CHAN   = 3'd2;
    localparam logic [2:0] REG_DST_WIDTH  = 3'd3;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd4;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;
endpackage

@@ src/bir_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One optional write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module bir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ src/bilinear_image_resize.sv @@
// ----------------------------------------------------------------------------
// Bilinear image resize
// Planar source store with a sequenced bilinear resampler.
// ----------------------------------------------------------------------------
// Channel  Dir  Transfer contents
// s_axis   in   tdata: opcode, col, row, chan, sample_in
// m_axis   out  tdata: status, sample_out
// cfg      in   register index and write data
//
// A write goes through the store state and the done state before its result is
// offered; a rejected item goes straight to the done state. A compute runs two
// coordinate divisions, one quotient bit per cycle through a shared subtractor,
// then four reads share the single store port and three blends share one
// multiply-add stage. One item is in work at a time; the block accepts the next
// item once the result register is free. Reset is synchronous, active low, and
// clears control state and the configuration registers only.
module bilinear_image_resize
    import bir_pkg::*;
#(
    parameter int P_MAX_SRC_WIDTH  = bir_pkg::MAX_SRC_WIDTH,
    parameter int P_MAX_SRC_HEIGHT = bir_pkg::MAX_SRC_HEIGHT,
    parameter int P_MAX_CHANNELS   = bir_pkg::MAX_CHANNELS,
    parameter int P_SAMPLE_BITS    = bir_pkg::SAMPLE_BITS,
    parameter int P_MAX_DST_DIM    = bir_pkg::MAX_DST_DIM
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[0], col[12:1], row[24:13], chan[26:25], sample_in[42:27], zero fill
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[0], sample_out[16:1], zero fill
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    localparam int PLANE = P_MAX_SRC_WIDTH * P_MAX_SRC_HEIGHT;
    localparam int DEPTH = PLANE * P_MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = (P_MAX_SRC_WIDTH > 1) ? $clog2(P_MAX_SRC_WIDTH) : 1;
    localparam int YW    = (P_MAX_SRC_HEIGHT > 1) ? $clog2(P_MAX_SRC_HEIGHT) : 1;
    localparam int DW    = $clog2(P_MAX_DST_DIM + 1);
    localparam int NW    = 13 + 12 + 2 + 16;
    localparam int QW    = NW;
    localparam int DVW   = DW + 1;
    localparam int SB    = P_SAMPLE_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_WSTORE, S_DIV, S_MAPY, S_RD, S_WAIT, S_BLEND, S_MULW, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [8:0]  sw_cfg_reg, sh_cfg_reg;
    logic [1:0]  nc_cfg_reg;
    logic [12:0] dw_cfg_reg, dh_cfg_reg;
    logic        opcode;
    logic [11:0] col_in, row_in, col_reg, row_reg;
    logic [1:0]  chan_in, chan_reg;
    logic [15:0] sample_in;
    logic        out_valid_reg;
    logic        out_status_reg;
    logic [15:0] out_sample_reg;

    logic [12:0] sw, sh, dw, dh;
    logic [1:0]  nc;
    logic [QW-1:0] rem_reg, quo_reg, num_reg;
    logic [DVW-1:0] den_reg;
    logic [5:0]  bit_reg;
    logic        axis_reg;
    logic [XW-1:0] x0_reg, x1_reg;
    logic [YW-1:0] y0_reg, y1_reg;
    logic [16:0] fx_reg, fy_reg;
    logic [1:0]  rd_reg;
    logic [2:0]  bl_reg;
    logic [SB-1:0] p_reg [4];
    logic [SB-1:0] q1_reg, q2_reg;
    logic [SB+17:0] acc_reg;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [SB-1:0] ram_rdata;
    logic [QW:0]   trial;
    logic [QW-1:0] q_done, u_val;
    logic [QW-16:0] ip1;
    logic [SB-1:0] ma, mb;
    logic [16:0]   mf;
    logic [SB+17:0] prod;

    function automatic logic [12:0] clampv(input logic [12:0] v, input int hi);
        if (v == 13'd0) return 13'd1;
        if (int'(v) > hi) return 13'(hi);
        return v;
    endfunction

    assign opcode    = s_axis_tdata[0];
    assign col_in    = s_axis_tdata[12:1];
    assign row_in    = s_axis_tdata[24:13];
    assign chan_in   = s_axis_tdata[26:25];
    assign sample_in = s_axis_tdata[42:27];

    assign sw = clampv({4'd0, sw_cfg_reg}, P_MAX_SRC_WIDTH);
    assign sh = clampv({4'd0, sh_cfg_reg}, P_MAX_SRC_HEIGHT);
    assign nc = 2'(clampv({11'd0, nc_cfg_reg}, P_MAX_CHANNELS));
    assign dw = clampv(dw_cfg_reg, P_MAX_DST_DIM);
    assign dh = clampv(dh_cfg_reg, P_MAX_DST_DIM);

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_sample_reg, out_status_reg};

    // Restoring division, one quotient bit per cycle.
    assign trial  = {rem_reg, num_reg[QW-1]} - {{(QW+1-DVW){1'b0}}, den_reg};
    assign q_done = quo_reg;
    assign u_val  = q_done + QW'(32768);
    assign ip1    = {1'b0, u_val[QW-1:16]};

    function automatic logic [12:0] clamp_idx(input logic [QW-16:0] p1, input int off,
                                              input logic [12:0] size);
        logic [QW-15:0] v;
        v = {1'b0, p1} + (QW-14)'(off);
        if (v == '0) return 13'd0;
        if ((v - 1'b1) >= (QW-14)'(size)) return size - 13'd1;
        return 13'(v - 1'b1);
    endfunction

    always_comb begin
        ram_we   = (state_reg == S_WSTORE);
        ram_addr = AW'(chan_reg) * AW'(PLANE) + AW'(row_reg) * AW'(P_MAX_SRC_WIDTH)
                 + AW'(col_reg);
        if (state_reg == S_RD) begin
            ram_addr = AW'(chan_reg) * AW'(PLANE)
                     + AW'(rd_reg[1] ? y1_reg : y0_reg) * AW'(P_MAX_SRC_WIDTH)
                     + AW'(rd_reg[0] ? x1_reg : x0_reg);
        end
    end

    bir_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (SB'(p_reg[0])),
        .rdata (ram_rdata)
    );

    always_comb begin
        case (bl_reg)
            3'd0:    begin ma = p_reg[0]; mb = p_reg[2]; mf = fy_reg; end
            3'd1:    begin ma = p_reg[1]; mb = p_reg[3]; mf = fy_reg; end
            default: begin ma = q1_reg;   mb = q2_reg;   mf = fx_reg; end
        endcase
        prod = (SB+18)'(ma) * (SB+18)'(17'h10000 - mf) + (SB+18)'(mb) * (SB+18)'(mf);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_axis_tvalid && s_axis_tready) begin
                          if (opcode == OP_WRITE) begin
                              state_next = ({1'b0, col_in} >= sw || {1'b0, row_in} >= sh
                                            || chan_in >= nc) ? S_DONE : S_WSTORE;
                          end else begin
                              state_next = ({1'b0, col_in} >= dw || {1'b0, row_in} >= dh
                                            || chan_in >= nc) ? S_DONE : S_DIV;
                          end
                      end
            S_WSTORE: state_next = S_DONE;
            S_DIV:    if (bit_reg == 6'd0) state_next = S_MAPY;
            S_MAPY:   state_next = axis_reg ? S_RD : S_DIV;
            S_RD:     if (rd_reg == 2'd3) state_next = S_WAIT;
            S_WAIT:   state_next = S_BLEND;
            S_BLEND:  state_next = S_MULW;
            S_MULW:   state_next = (bl_reg == 3'd2) ? S_DONE : S_BLEND;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            sw_cfg_reg    <= 9'd256;
            sh_cfg_reg    <= 9'd256;
            nc_cfg_reg    <= 2'd3;
            dw_cfg_reg    <= 13'd256;
            dh_cfg_reg    <= 13'd256;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SRC_WIDTH:  sw_cfg_reg <= cfg_data[8:0];
                    REG_SRC_HEIGHT: sh_cfg_reg <= cfg_data[8:0];
                    REG_NUM_CHAN:   nc_cfg_reg <= cfg_data[1:0];
                    REG_DST_WIDTH:  dw_cfg_reg <= cfg_data;
                    REG_DST_HEIGHT: dh_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_DONE) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                col_reg <= col_in; row_reg <= row_in;
                chan_reg <= chan_in; p_reg[0] <= SB'(sample_in);
                out_sample_reg <= 16'd0;
                out_status_reg <= 1'b1;
                axis_reg <= 1'b0;
                rem_reg  <= '0; quo_reg <= '0; bit_reg <= 6'(QW-1);
                num_reg  <= QW'(sw * (26'({col_in, 1'b1})) ) << 16;
                den_reg  <= DVW'({dw, 1'b0});
                if ((opcode == OP_WRITE && !({1'b0, col_in} >= sw || {1'b0, row_in} >= sh
                     || chan_in >= nc)) ||
                    (opcode == OP_COMPUTE && !({1'b0, col_in} >= dw || {1'b0, row_in} >= dh
                     || chan_in >= nc)))
                    out_status_reg <= 1'b0;
            end
            S_DIV: begin
                if (!trial[QW]) begin
                    rem_reg <= trial[QW-1:0];
                    quo_reg <= {quo_reg[QW-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[QW-2:0], num_reg[QW-1]};
                    quo_reg <= {quo_reg[QW-2:0], 1'b0};
                end
                num_reg <= {num_reg[QW-2:0], 1'b0};
                bit_reg <= bit_reg - 6'd1;
            end
            S_MAPY: begin
                if (!axis_reg) begin
                    x0_reg <= XW'(clamp_idx(ip1, 0, sw));
                    x1_reg <= XW'(clamp_idx(ip1, 1, sw));
                    fx_reg <= {1'b0, u_val[15:0]};
                    num_reg <= QW'(sh * (26'({row_reg, 1'b1}))) << 16;
                    den_reg <= DVW'({dh, 1'b0});
                end else begin
                    y0_reg <= YW'(clamp_idx(ip1, 0, sh));
                    y1_reg <= YW'(clamp_idx(ip1, 1, sh));
                    fy_reg <= {1'b0, u_val[15:0]};
                end
                axis_reg <= 1'b1;
                rem_reg <= '0; quo_reg <= '0; bit_reg <= 6'(QW-1);
                rd_reg <= 2'd0;
                bl_reg <= 3'd0;
            end
            S_RD: begin
                rd_reg <= rd_reg + 2'd1;
                if (rd_reg != 2'd0) p_reg[rd_reg - 2'd1] <= ram_rdata;
            end
            S_WAIT:  p_reg[3] <= ram_rdata;
            S_BLEND: acc_reg <= prod + (SB+18)'(32768);
            S_MULW: begin
                case (bl_reg)
                    3'd0:    q1_reg <= SB'(acc_reg >> 16);
                    3'd1:    q2_reg <= SB'(acc_reg >> 16);
                    default: out_sample_reg <= 16'(acc_reg >> 16);
                endcase
                bl_reg <= bl_reg + 3'd1;
            end
            default: ;
        endcase
    end
endmodule

@@ src/bir_checker.sv @@
// ----------------------------------------------------------------------------
// Bilinear image resize checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
module bir_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    // A result stays offered until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");
    // No input is taken while a result waits.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted with a pending result");
    // A rejected item carries a zero sample.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[16:1] == 16'd0)
        else $error("error result with nonzero sample");
    // Accepting an input closes the input side next cycle.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transfer while busy");
endmodule

bind bilinear_image_resize bir_checker u_bir_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

@@ test/tb_bilinear_image_resize.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bilinear image resize testbench
// Loads small source images, resamples them at several register settings
// and compares every result with a behavioral predictor of the resampler.
// ----------------------------------------------------------------------------
module tb_bilinear_image_resize;
    import bir_pkg::*;

    typedef struct packed {
        logic [15:0] sample_in;
        logic [1:0]  chan;
        logic [11:0] row;
        logic [11:0] col;
        logic        opcode;
    } pixel_req_t;

    typedef struct packed {
        logic [15:0] sample_out;
        logic        status;
    } pixel_rsp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;

    bilinear_image_resize u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    logic [15:0] pixel_mem [0:MAX_CHANNELS*MAX_SRC_HEIGHT*MAX_SRC_WIDTH-1];
    logic [8:0]  reg_src_w = 9'd256, reg_src_h = 9'd256;
    logic [1:0]  reg_chans = 2'd3;
    logic [12:0] reg_dst_w = 13'd256, reg_dst_h = 13'd256;

    pixel_req_t pending_reqs[$];
    pixel_rsp_t expected_pixels[$];
    int         mismatches = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         stall_phase = 0;
    bit         hold_sender = 1'b0;

    function automatic int clamp_size(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int clamp_pos(longint v, int size);
        if (v < 0) return 0;
        if (v >= size) return size - 1;
        return int'(v);
    endfunction

    function automatic longint mix(longint a, longint b, longint f);
        return (a * (65536 - f) + b * f + 32768) >>> 16;
    endfunction

    function automatic void axis_position(int src, int dst, int d,
                                          output longint ip, output longint fr);
        longint q, u;
        q = (longint'(src) * (2 * d + 1) * 65536) / (2 * longint'(dst));
        u = q + 32768;
        ip = (u >>> 16) - 1;
        fr = u & 16'hFFFF;
    endfunction

    function automatic int mem_addr(int c, int y, int x);
        return c * MAX_SRC_HEIGHT * MAX_SRC_WIDTH + y * MAX_SRC_WIDTH + x;
    endfunction

    function automatic pixel_rsp_t resample(pixel_req_t r);
        pixel_rsp_t o;
        int sw, sh, nc, dw, dh, x0, x1, y0, y1;
        longint ix, iy, fx, fy, p1, p2, p3, p4;
        sw = clamp_size(reg_src_w, MAX_SRC_WIDTH);
        sh = clamp_size(reg_src_h, MAX_SRC_HEIGHT);
        nc = clamp_size(reg_chans, MAX_CHANNELS);
        dw = clamp_size(reg_dst_w, MAX_DST_DIM);
        dh = clamp_size(reg_dst_h, MAX_DST_DIM);
        o = '0;
        if (r.opcode == OP_WRITE) begin
            if (r.col >= sw || r.row >= sh || r.chan >= nc) o.status = 1'b1;
            else pixel_mem[mem_addr(r.chan, r.row, r.col)] = r.sample_in;
            return o;
        end
        if (r.col >= dw || r.row >= dh || r.chan >= nc) begin
            o.status = 1'b1;
            return o;
        end
        axis_position(sw, dw, r.col, ix, fx);
        axis_position(sh, dh, r.row, iy, fy);
        x0 = clamp_pos(ix, sw);
        x1 = clamp_pos(ix + 1, sw);
        y0 = clamp_pos(iy, sh);
        y1 = clamp_pos(iy + 1, sh);
        p1 = pixel_mem[mem_addr(r.chan, y0, x0)];
        p2 = pixel_mem[mem_addr(r.chan, y0, x1)];
        p3 = pixel_mem[mem_addr(r.chan, y1, x0)];
        p4 = pixel_mem[mem_addr(r.chan, y1, x1)];
        o.sample_out = 16'(mix(mix(p1, p3, fy), mix(p2, p4, fy), fx));
        return o;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        pixel_req_t r;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                r = pixel_req_t'(s_axis_tdata[42:0]);
                expected_pixels.push_back(resample(r));
            end
            if (s_axis_tvalid && !s_axis_tready) begin
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_sender) begin
                r = pending_reqs.pop_front();
                s_axis_tdata <= {5'd0, r};
                s_axis_tvalid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stalls on a rotating pattern with random depth.
    always @(posedge aclk) begin
        pixel_rsp_t got, want;
        if (aresetn) begin
            stall_phase <= (stall_phase + 1) % 97;
            m_axis_tready <= (stall_phase < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
            if (m_axis_tvalid && m_axis_tready) begin
                got = pixel_rsp_t'(m_axis_tdata[16:0]);
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.status !== want.status || got.sample_out !== want.sample_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected status %0d sample %h, got status %0d sample %h",
                                     want.status, want.sample_out, got.status, got.sample_out);
                    end
                end
            end
        end
    end

    task automatic drain_block();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [12:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  reg_src_w = val[8:0];
            REG_SRC_HEIGHT: reg_src_h = val[8:0];
            REG_NUM_CHAN:   reg_chans = val[1:0];
            REG_DST_WIDTH:  reg_dst_w = val;
            REG_DST_HEIGHT: reg_dst_h = val;
            default: ;
        endcase
    endtask

    function automatic pixel_req_t make_req(logic op, int c, int r, int ch, int s);
        pixel_req_t q;
        q.opcode = op;
        q.col = 12'(c);
        q.row = 12'(r);
        q.chan = 2'(ch);
        q.sample_in = 16'(s);
        return q;
    endfunction

    // Fills the used part of the image so every compute reads written data.
    task automatic load_image(int w, int h, int nc);
        for (int c = 0; c < nc; c++)
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                    pending_reqs.push_back(make_req(OP_WRITE, x, y, c, $urandom_range(0, 65535)));
    endtask

    task automatic run_phase(int sw, int sh, int nc, int dw, int dh, int n);
        int ew, eh, en;
        write_reg(REG_SRC_WIDTH, 13'(sw));
        write_reg(REG_SRC_HEIGHT, 13'(sh));
        write_reg(REG_NUM_CHAN, 13'(nc));
        write_reg(REG_DST_WIDTH, 13'(dw));
        write_reg(REG_DST_HEIGHT, 13'(dh));
        ew = clamp_size(sw[8:0], MAX_SRC_WIDTH);
        eh = clamp_size(sh[8:0], MAX_SRC_HEIGHT);
        en = clamp_size(nc[1:0], MAX_CHANNELS);
        load_image(ew, eh, en);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                pending_reqs.push_back(make_req(OP_WRITE, $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 3), $urandom_range(0, 65535)));
            else if ($urandom_range(0, 9) == 0)
                pending_reqs.push_back(make_req(OP_COMPUTE, $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 3), $urandom_range(0, 65535)));
            else
                pending_reqs.push_back(make_req(OP_COMPUTE,
                    $urandom_range(0, clamp_size(dw[12:0], MAX_DST_DIM) - 1),
                    $urandom_range(0, clamp_size(dh[12:0], MAX_DST_DIM) - 1),
                    $urandom_range(0, en - 1), $urandom_range(0, 65535)));
        end
        drain_block();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(REG_SRC_WIDTH, 13'd2);
        write_reg(REG_SRC_HEIGHT, 13'd2);
        write_reg(REG_NUM_CHAN, 13'd1);
        write_reg(REG_DST_WIDTH, 13'd4);
        write_reg(REG_DST_HEIGHT, 13'd4);
        write_reg(3'd7, 13'h1FFF);
        write_reg(3'd5, 13'd1);
        load_image(2, 2, 1);
        pending_reqs.push_back(make_req(OP_WRITE, 0, 0, 0, 16'hFFFF));
        pending_reqs.push_back(make_req(OP_WRITE, 1, 1, 0, 0));
        pending_reqs.push_back(make_req(OP_WRITE, 2, 0, 0, 5));
        pending_reqs.push_back(make_req(OP_WRITE, 0, 2, 0, 5));
        pending_reqs.push_back(make_req(OP_WRITE, 0, 0, 1, 5));
        pending_reqs.push_back(make_req(OP_WRITE, 4095, 4095, 3, 16'hAAAA));
        pending_reqs.push_back(make_req(OP_COMPUTE, 0, 0, 0, 16'h5555));
        pending_reqs.push_back(make_req(OP_COMPUTE, 3, 3, 0, 0));
        pending_reqs.push_back(make_req(OP_COMPUTE, 1, 2, 0, 0));
        pending_reqs.push_back(make_req(OP_COMPUTE, 4, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_COMPUTE, 0, 4, 0, 0));
        pending_reqs.push_back(make_req(OP_COMPUTE, 0, 0, 2, 0));
        pending_reqs.push_back(make_req(OP_COMPUTE, 4095, 4095, 3, 16'hFFFF));
        repeat (40) @(posedge aclk);

        // The sender holds off until the block has answered everything.
        hold_sender = 1'b1;
        while (expected_pixels.size() > 0 || s_axis_tvalid) @(posedge aclk);
        hold_sender = 1'b0;
        drain_block();

        run_phase(0, 0, 0, 0, 0, 20);
        run_phase(1, 1, 1, 4096, 4096, 20);
        run_phase(5, 3, 3, 11, 7, 50);
        run_phase(4, 6, 2, 3, 2, 30);
        run_phase(9'h1FF, 1, 1, 13'h1FFF, 5, 30);
        run_phase(3, 2, 1, 1, 1, 20);

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
